// ----- design/stack_arithmetic_engine_core_defines.svh -----
// Assertion macros for the stack arithmetic engine.
// Used by the top level only; no other dependencies.
`ifndef STACK_ARITHMETIC_ENGINE_CORE_DEFINES_SVH
`define STACK_ARITHMETIC_ENGINE_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define SAE_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define SAE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define SAE_ASSERT_SAME(label, ante, cons)
`define SAE_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ----- design/sae_pkg.sv -----
// Shared types and constants for the stack arithmetic engine.
// No dependencies.
`timescale 1ns / 1ps

package sae_pkg;

    localparam int STACK_DEPTH = 256;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
    localparam int WORD_W      = 32;
    localparam int FUNC_W      = 4;
    localparam int ERR_W       = 2;

    localparam logic [FUNC_W-1:0] FN_PUSH  = 4'd0;
    localparam logic [FUNC_W-1:0] FN_POP   = 4'd1;
    localparam logic [FUNC_W-1:0] FN_DUP   = 4'd2;
    localparam logic [FUNC_W-1:0] FN_SWAP  = 4'd3;
    localparam logic [FUNC_W-1:0] FN_ADD   = 4'd4;
    localparam logic [FUNC_W-1:0] FN_SUB   = 4'd5;
    localparam logic [FUNC_W-1:0] FN_MUL   = 4'd6;
    localparam logic [FUNC_W-1:0] FN_DIV   = 4'd7;
    localparam logic [FUNC_W-1:0] FN_MOD   = 4'd8;
    localparam logic [FUNC_W-1:0] FN_CLEAR = 4'd9;

    localparam logic [ERR_W-1:0] ERR_OK   = 2'd0;
    localparam logic [ERR_W-1:0] ERR_UNF  = 2'd1;
    localparam logic [ERR_W-1:0] ERR_OVF  = 2'd2;
    localparam logic [ERR_W-1:0] ERR_DIV0 = 2'd3;

    typedef struct packed {
        logic [FUNC_W-1:0]        func;
        logic signed [WORD_W-1:0] value;
    } sae_req_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] top_value;
        logic [DEPTH_W-1:0]       depth;
        logic [ERR_W-1:0]         error;
    } sae_rsp_t;

    typedef struct packed {
        logic capture;
        logic load;
        logic exec;
        logic div_start;
        logic commit;
    } sae_cmd_t;

    typedef struct packed {
        logic need_div;
        logic div_done;
    } sae_stat_t;

endpackage

// ----- design/sae_ram.sv -----
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module sae_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- design/sae_div.sv -----
// Iterative signed divider, one quotient bit per cycle, truncating.
// Depends on sae_pkg.
`timescale 1ns / 1ps

module sae_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [sae_pkg::WORD_W-1:0]  dividend,
    input  logic [sae_pkg::WORD_W-1:0]  divisor,
    output logic                        done,
    output logic [sae_pkg::WORD_W-1:0]  quotient,
    output logic [sae_pkg::WORD_W-1:0]  remainder
);
    import sae_pkg::*;

    localparam int CNT_W = $clog2(WORD_W + 1);

    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [WORD_W-1:0] rem_reg, rem_next;
    logic [WORD_W-1:0] quo_reg, quo_next;
    logic [WORD_W-1:0] dvs_reg, dvs_next;
    logic              neg_q_reg, neg_q_next;
    logic              neg_r_reg, neg_r_next;
    logic [WORD_W:0]   shifted;
    logic [WORD_W:0]   diff;

    assign shifted = {rem_reg, quo_reg[WORD_W-1]};
    assign diff    = shifted - {1'b0, dvs_reg};

    always_comb
    begin
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        dvs_next   = dvs_reg;
        neg_q_next = neg_q_reg;
        neg_r_next = neg_r_reg;
        if (start)
        begin
            cnt_next   = CNT_W'(WORD_W);
            rem_next   = '0;
            quo_next   = dividend[WORD_W-1] ? (~dividend + 1'b1) : dividend;
            dvs_next   = divisor[WORD_W-1] ? (~divisor + 1'b1) : divisor;
            neg_q_next = dividend[WORD_W-1] ^ divisor[WORD_W-1];
            neg_r_next = dividend[WORD_W-1];
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (!diff[WORD_W])
            begin
                rem_next = diff[WORD_W-1:0];
                quo_next = {quo_reg[WORD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[WORD_W-1:0];
                quo_next = {quo_reg[WORD_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        dvs_reg   <= dvs_next;
        neg_q_reg <= neg_q_next;
        neg_r_reg <= neg_r_next;
    end

    assign done      = (cnt_reg == '0);
    assign quotient  = neg_q_reg ? (~quo_reg + 1'b1) : quo_reg;
    assign remainder = neg_r_reg ? (~rem_reg + 1'b1) : rem_reg;

endmodule

// ----- design/sae_dpath.sv -----
// Datapath: top-of-stack register, stack RAM, ALU, divider, result register.
// Depends on sae_pkg, sae_ram and sae_div.
`timescale 1ns / 1ps

module sae_dpath (
    input  logic               clk,
    input  logic               rst_n,
    input  sae_pkg::sae_req_t  req,
    input  sae_pkg::sae_cmd_t  cmd,
    output sae_pkg::sae_stat_t stat,
    output sae_pkg::sae_rsp_t  rsp
);
    import sae_pkg::*;

    logic [FUNC_W-1:0]  func_reg;
    logic [WORD_W-1:0]  value_reg;
    logic [WORD_W-1:0]  top_reg, top_next;
    logic [DEPTH_W-1:0] count_reg, count_next;
    logic [WORD_W-1:0]  res_reg, res_next;
    logic [ERR_W-1:0]   err_reg, err_next;
    sae_rsp_t           rsp_reg;

    logic [WORD_W-1:0]  rd_data;
    logic [ADDR_W-1:0]  rd_addr;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic               is_divmod;
    logic               full;
    logic               ok;
    logic               div_done;
    logic [WORD_W-1:0]  quotient;
    logic [WORD_W-1:0]  remainder;
    logic [WORD_W-1:0]  arith_res;

    assign rd_addr   = ADDR_W'(count_reg - DEPTH_W'(2));
    assign is_divmod = (func_reg == FN_DIV) || (func_reg == FN_MOD);
    assign full      = (count_reg >= DEPTH_W'(STACK_DEPTH));
    assign ok        = (err_reg == ERR_OK);

    sae_ram #(
        .WIDTH(WORD_W),
        .DEPTH(STACK_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (top_reg),
        .rd_en   (cmd.load),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    sae_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (top_reg),
        .divisor   (rd_data),
        .done      (div_done),
        .quotient  (quotient),
        .remainder (remainder)
    );

    // error check and combinational results, evaluated with RAM data in hand
    always_comb
    begin
        err_next = ERR_OK;
        res_next = top_reg;
        unique case (func_reg)
            FN_PUSH:
            begin
                res_next = value_reg;
                if (full)
                begin
                    err_next = ERR_OVF;
                end
            end
            FN_POP:
            begin
                res_next = rd_data;
                if (count_reg < DEPTH_W'(1))
                begin
                    err_next = ERR_UNF;
                end
            end
            FN_DUP:
            begin
                if (count_reg < DEPTH_W'(1))
                begin
                    err_next = ERR_UNF;
                end
                else if (full)
                begin
                    err_next = ERR_OVF;
                end
            end
            FN_SWAP:
            begin
                res_next = rd_data;
                if (count_reg < DEPTH_W'(2))
                begin
                    err_next = ERR_UNF;
                end
            end
            FN_ADD, FN_SUB, FN_MUL, FN_DIV, FN_MOD:
            begin
                if (func_reg == FN_ADD)
                begin
                    res_next = top_reg + rd_data;
                end
                else if (func_reg == FN_SUB)
                begin
                    res_next = top_reg - rd_data;
                end
                else
                begin
                    res_next = top_reg * rd_data;
                end
                if (count_reg < DEPTH_W'(2))
                begin
                    err_next = ERR_UNF;
                end
                else if (is_divmod && (rd_data == '0))
                begin
                    err_next = ERR_DIV0;
                end
            end
            default:
            begin
                err_next = ERR_OK;
            end
        endcase
    end

    assign stat.need_div = is_divmod && (err_next == ERR_OK);
    assign stat.div_done = div_done;

    assign arith_res = !is_divmod ? res_reg :
                       (func_reg == FN_DIV) ? quotient : remainder;

    always_comb
    begin
        top_next   = top_reg;
        count_next = count_reg;
        wr_en      = 1'b0;
        wr_addr    = ADDR_W'(count_reg - DEPTH_W'(1));
        if (ok)
        begin
            unique case (func_reg)
                FN_PUSH:
                begin
                    wr_en      = (count_reg != '0);
                    top_next   = res_reg;
                    count_next = count_reg + DEPTH_W'(1);
                end
                FN_POP:
                begin
                    top_next   = res_reg;
                    count_next = count_reg - DEPTH_W'(1);
                end
                FN_DUP:
                begin
                    wr_en      = 1'b1;
                    count_next = count_reg + DEPTH_W'(1);
                end
                FN_SWAP:
                begin
                    wr_en    = 1'b1;
                    wr_addr  = rd_addr;
                    top_next = res_reg;
                end
                FN_ADD, FN_SUB, FN_MUL, FN_DIV, FN_MOD:
                begin
                    top_next   = arith_res;
                    count_next = count_reg - DEPTH_W'(1);
                end
                FN_CLEAR:
                begin
                    count_next = '0;
                end
                default:
                begin
                    count_next = count_reg;
                end
            endcase
        end
        wr_en = wr_en && cmd.commit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.commit)
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg  <= req.func;
            value_reg <= req.value;
        end
        if (cmd.exec)
        begin
            res_reg <= res_next;
            err_reg <= err_next;
        end
        if (cmd.commit)
        begin
            top_reg           <= top_next;
            rsp_reg.top_value <= (count_next != '0) ? top_next : '0;
            rsp_reg.depth     <= count_next;
            rsp_reg.error     <= err_reg;
        end
    end

    assign rsp = rsp_reg;

endmodule

// ----- design/sae_ctrl.sv -----
// Controller: sequences load, execute, divide and commit for one request,
// and owns the result valid flag. Depends on sae_pkg.
`timescale 1ns / 1ps

module sae_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    input  sae_pkg::sae_stat_t stat,
    output sae_pkg::sae_cmd_t  cmd
);
    import sae_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_LOAD   = 3'd1;
    localparam logic [2:0] ST_EXEC   = 3'd2;
    localparam logic [2:0] ST_DIV    = 3'd3;
    localparam logic [2:0] ST_COMMIT = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       valid_reg, valid_next;
    logic       out_free;

    assign out_free  = !valid_reg || !rsp_stall;
    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = valid_reg;

    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                cmd.load   = 1'b1;
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                cmd.exec = 1'b1;
                if (stat.need_div)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end
                else
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_DIV:
            begin
                if (stat.div_done)
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                if (out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        priority if (cmd.commit)
        begin
            valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

endmodule

// ----- design/stack_arithmetic_engine_core.sv -----
// Stack arithmetic engine: RPN stack machine on signed 32-bit words.
// Request channel: cmd_valid / cmd_stall carrying cmd (func, value).
// Result channel: result_valid / result_stall carrying result
//   (top_value, depth, error); exactly one result per request.
// A request is taken when valid is high and stall is low. cmd_stall is high
//   from the cycle after a request is taken until its result is registered.
// Each request passes through the load, execute and commit states; div and
//   mod without an error also pass through the divide state, where the
//   one-bit-per-cycle divider runs. A new request is taken only after the
//   result of the last one is registered.
// The top of stack lives in a register, the entries below it in a
//   256-word RAM read once per request; errors leave the stack unchanged.
// Reset clears the stack depth to zero; the RAM is not cleared.
// A stalled result holds in the result register; the next request is still
//   taken and executed, and its commit waits until the result register frees.
// Depends on sae_pkg, sae_ctrl, sae_dpath and the defines header.
`timescale 1ns / 1ps

`include "stack_arithmetic_engine_core_defines.svh"

module stack_arithmetic_engine_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_stall,
    input  sae_pkg::sae_req_t cmd,
    output logic              result_valid,
    input  logic              result_stall,
    output sae_pkg::sae_rsp_t result
);
    import sae_pkg::*;

    sae_cmd_t  ctl_cmd;
    sae_stat_t dp_stat;

    sae_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (cmd_valid),
        .req_stall (cmd_stall),
        .rsp_valid (result_valid),
        .rsp_stall (result_stall),
        .stat      (dp_stat),
        .cmd       (ctl_cmd)
    );

    sae_dpath u_dpath (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (cmd),
        .cmd   (ctl_cmd),
        .stat  (dp_stat),
        .rsp   (result)
    );

    `SAE_ASSERT_NEXT(a_stall_after_take, cmd_valid && !cmd_stall, cmd_stall)
    `SAE_ASSERT_SAME(a_depth_bound, result_valid, result.depth <= DEPTH_W'(STACK_DEPTH))
    `SAE_ASSERT_SAME(a_empty_zero, result_valid && (result.depth == '0), result.top_value == '0)
    `SAE_ASSERT_SAME(a_div0_depth, result_valid && (result.error == ERR_DIV0), result.depth >= DEPTH_W'(2))

endmodule

// ----- tb/tb.sv -----
// Testbench for stack_arithmetic_engine_core: directed and random request streams checked
// against a shadow stack kept in the bench. Depends on sae_pkg and the core RTL only.
`timescale 1ns / 1ps

module tb;
    import sae_pkg::*;

    localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh8000_0000;
    localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7fff_ffff;
    localparam int HOLD_AT     = 100;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_WAIT  = 40;
    localparam int RANDOM_REQS = 650;

    logic     clk          = 1'b0;
    logic     rst_n        = 1'b0;
    logic     cmd_valid    = 1'b0;
    logic     cmd_stall;
    sae_req_t cmd          = '0;
    logic     result_valid;
    logic     result_stall = 1'b0;
    sae_rsp_t result;

    sae_req_t          pending_requests[$];
    sae_rsp_t          expected_results[$];
    logic [WORD_W-1:0] shadow_mem[STACK_DEPTH];
    int                shadow_count = 0;
    int                gen_depth    = 0;
    int                n_total      = 0;
    int                n_accepted   = 0;
    int                n_errors     = 0;
    int                hold_left    = 0;
    bit                hold_done    = 1'b0;

    stack_arithmetic_engine_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_valid),
        .cmd_stall    (cmd_stall),
        .cmd          (cmd),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always #10 clk = ~clk;

    function automatic sae_rsp_t exec_on_shadow(sae_req_t req);
        sae_rsp_t          rsp;
        logic [ERR_W-1:0]  err;
        logic [WORD_W-1:0] lhs;
        logic [WORD_W-1:0] rhs;
        logic [WORD_W-1:0] tmp;
        longint            sl;
        longint            sr;
        longint            q;
        int                n;
        err = ERR_OK;
        n = shadow_count;
        case (req.func)
            FN_PUSH:
                if (n >= STACK_DEPTH)
                    err = ERR_OVF;
                else
                begin
                    shadow_mem[n] = req.value;
                    n++;
                end
            FN_POP:
                if (n < 1)
                    err = ERR_UNF;
                else
                    n--;
            FN_DUP:
                if (n < 1)
                    err = ERR_UNF;
                else if (n >= STACK_DEPTH)
                    err = ERR_OVF;
                else
                begin
                    shadow_mem[n] = shadow_mem[n-1];
                    n++;
                end
            FN_SWAP:
                if (n < 2)
                    err = ERR_UNF;
                else
                begin
                    tmp = shadow_mem[n-1];
                    shadow_mem[n-1] = shadow_mem[n-2];
                    shadow_mem[n-2] = tmp;
                end
            FN_ADD, FN_SUB, FN_MUL, FN_DIV, FN_MOD:
                if (n < 2)
                    err = ERR_UNF;
                else
                begin
                    // top is the left operand
                    lhs = shadow_mem[n-1];
                    rhs = shadow_mem[n-2];
                    sl = $signed(lhs);
                    sr = $signed(rhs);
                    if ((req.func == FN_DIV || req.func == FN_MOD) && rhs == '0)
                        err = ERR_DIV0;
                    else
                    begin
                        case (req.func)
                            FN_ADD: shadow_mem[n-2] = lhs + rhs;
                            FN_SUB: shadow_mem[n-2] = lhs - rhs;
                            FN_MUL: shadow_mem[n-2] = lhs * rhs;
                            FN_DIV:
                            begin
                                q = sl / sr;
                                shadow_mem[n-2] = q[WORD_W-1:0];
                            end
                            default:
                            begin
                                q = sl % sr;
                                shadow_mem[n-2] = q[WORD_W-1:0];
                            end
                        endcase
                        n--;
                    end
                end
            FN_CLEAR: n = 0;
            default: ;
        endcase
        shadow_count = n;
        rsp.top_value = (n > 0) ? shadow_mem[n-1] : '0;
        rsp.depth = n[DEPTH_W-1:0];
        rsp.error = err;
        return rsp;
    endfunction

    function automatic logic signed [WORD_W-1:0] rand_word();
        case ($urandom_range(0, 9))
            0: return WORD_MIN;
            1: return WORD_MAX;
            2, 3, 4: return int'($urandom_range(0, 6)) - 3;
            default: return $urandom();
        endcase
    endfunction

    // gen_depth is only a rough guess used to shape the stream
    function automatic void queue_request(logic [FUNC_W-1:0] f, logic signed [WORD_W-1:0] v);
        sae_req_t r;
        r.func = f;
        r.value = v;
        pending_requests.push_back(r);
        case (f)
            FN_PUSH: if (gen_depth < STACK_DEPTH) gen_depth++;
            FN_POP: if (gen_depth > 0) gen_depth--;
            FN_DUP: if (gen_depth > 0 && gen_depth < STACK_DEPTH) gen_depth++;
            FN_ADD, FN_SUB, FN_MUL, FN_DIV, FN_MOD: if (gen_depth >= 2) gen_depth--;
            FN_CLEAR: gen_depth = 0;
            default: ;
        endcase
    endfunction

    function automatic int idle_pct(bit sender);
        if (n_accepted * 3 < n_total)
            return sender ? 30 : 71;
        if (n_accepted * 3 < n_total * 2)
            return sender ? 71 : 30;
        return 0;
    endfunction

    // request driver
    always @(posedge clk)
    begin
        if (!rst_n)
            cmd_valid <= 1'b0;
        else
        begin
            if (cmd_valid && !cmd_stall)
            begin
                expected_results.push_back(exec_on_shadow(cmd));
                n_accepted <= n_accepted + 1;
            end
            if (!cmd_valid || !cmd_stall)
            begin
                if (pending_requests.size() != 0 &&
                    (hold_left != 0 || $urandom_range(0, 99) >= idle_pct(1'b1)))
                begin
                    cmd <= pending_requests.pop_front();
                    cmd_valid <= 1'b1;
                end
                else
                    cmd_valid <= 1'b0;
            end
        end
    end

    // result stall, with one long hold-off to back up the core
    always @(posedge clk)
    begin
        if (!rst_n)
            result_stall <= 1'b0;
        else if (hold_left > 0)
        begin
            result_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (!hold_done && n_accepted >= HOLD_AT)
        begin
            result_stall <= 1'b1;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else
            result_stall <= ($urandom_range(0, 99) < idle_pct(1'b0));
    end

    // result monitor
    always @(posedge clk)
    begin : monitor
        sae_rsp_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result with no request pending: top_value %0d depth %0d error %0d",
                       result.top_value, result.depth, result.error);
                n_errors++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (result.top_value !== want.top_value)
                begin
                    $error("top_value: expected %0d, actual %0d", want.top_value,
                           result.top_value);
                    n_errors++;
                end
                if (result.depth !== want.depth)
                begin
                    $error("depth: expected %0d, actual %0d", want.depth, result.depth);
                    n_errors++;
                end
                if (result.error !== want.error)
                begin
                    $error("error: expected %0d, actual %0d", want.error, result.error);
                    n_errors++;
                end
            end
        end
    end

    initial
    begin
        int r;
        // directed: empty stack, min / -1, zero divisor, wrap, unused codes
        queue_request(FN_POP, rand_word());
        queue_request(FN_DUP, rand_word());
        queue_request(FN_SWAP, rand_word());
        queue_request(FN_ADD, rand_word());
        queue_request(FN_CLEAR, rand_word());
        queue_request(FN_PUSH, -1);
        queue_request(FN_SWAP, rand_word());
        queue_request(FN_DIV, rand_word());
        queue_request(FN_PUSH, WORD_MIN);
        queue_request(FN_DUP, rand_word());
        queue_request(FN_POP, rand_word());
        queue_request(FN_DIV, rand_word());
        queue_request(FN_PUSH, -1);
        queue_request(FN_SWAP, rand_word());
        queue_request(FN_MOD, rand_word());
        queue_request(FN_PUSH, WORD_MAX);
        queue_request(FN_DIV, rand_word());
        queue_request(FN_MOD, rand_word());
        queue_request(FN_DUP, rand_word());
        queue_request(FN_ADD, rand_word());
        queue_request(FN_PUSH, -7);
        queue_request(FN_SUB, rand_word());
        queue_request(FN_PUSH, 3);
        queue_request(FN_MUL, rand_word());
        queue_request(FUNC_W'(FN_CLEAR + 1), rand_word());
        queue_request(FUNC_W'((1 << FUNC_W) - 1), rand_word());
        queue_request(FN_CLEAR, rand_word());

        // fill to the top, then overflow and work on a full stack
        while (gen_depth < STACK_DEPTH)
            queue_request(($urandom_range(0, 3) == 0) ? FN_DUP : FN_PUSH, rand_word());
        queue_request(FN_PUSH, rand_word());
        queue_request(FN_DUP, rand_word());
        queue_request(FN_PUSH, rand_word());
        queue_request(FN_DUP, rand_word());
        for (int i = 0; i < 3; i++)
        begin
            queue_request(FN_SWAP, rand_word());
            queue_request(FN_ADD, rand_word());
            queue_request(FN_SUB, rand_word());
            queue_request(FN_MUL, rand_word());
            queue_request(FN_DIV, rand_word());
            queue_request(FN_MOD, rand_word());
            queue_request(FN_POP, rand_word());
        end
        queue_request(FN_CLEAR, rand_word());

        for (int i = 0; i < RANDOM_REQS; i++)
        begin
            r = $urandom_range(0, 99);
            if ((gen_depth < 2 && r < 70) || r < 30)
                queue_request(FN_PUSH, rand_word());
            else if (r < 38)
                queue_request(FN_POP, rand_word());
            else if (r < 46)
                queue_request(FN_DUP, rand_word());
            else if (r < 54)
                queue_request(FN_SWAP, rand_word());
            else if (r < 61)
                queue_request(FN_ADD, rand_word());
            else if (r < 68)
                queue_request(FN_SUB, rand_word());
            else if (r < 75)
                queue_request(FN_MUL, rand_word());
            else if (r < 85)
                queue_request(FN_DIV, rand_word());
            else if (r < 95)
                queue_request(FN_MOD, rand_word());
            else if (r < 97)
                queue_request(FN_CLEAR, rand_word());
            else
                queue_request(FUNC_W'($urandom_range(FN_CLEAR + 1, (1 << FUNC_W) - 1)),
                              rand_word());
        end
        n_total = pending_requests.size();

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (n_accepted < n_total || expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (n_errors == 0)
            $display("stack_arithmetic_engine_core test passed");
        else
            $display("stack_arithmetic_engine_core test failed");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("stack_arithmetic_engine_core test failed");
        $finish;
    end

endmodule
